// ===== sv/omct_pkg.sv =====
// Shared types and constants for the optical media change tracker.
// Holds the input and result word layouts, item kinds and event codes.
// No dependencies.
`timescale 1ns / 1ps

package omct_pkg;

    // The generation counter width can be set from 8 to 64 bits.
    localparam int GEN_W = 64;

    // Item kinds carried in the kind field.
    typedef enum logic [1:0] {
        KIND_EVENT   = 2'd0,
        KIND_SENSE   = 2'd1,
        KIND_READY   = 2'd2,
        KIND_SESSION = 2'd3
    } kind_t;

    // Observed event codes reported in the result word.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_EJECT   = 3'd1;
    localparam logic [2:0] EV_NEW     = 3'd2;
    localparam logic [2:0] EV_REMOVAL = 3'd3;
    localparam logic [2:0] EV_CHANGED = 3'd4;

    // Event response header fields.
    localparam logic [7:0]  EV_MIN_LEN      = 8'd4;
    localparam logic [7:0]  EV_FULL_LEN     = 8'd8;
    localparam logic [2:0]  EV_CLASS_MEDIA  = 3'd4;
    localparam logic [15:0] EV_MIN_PAYLOAD  = 16'd6;

    // Sense response codes and lengths.
    localparam logic [6:0] RC_FIXED_CUR  = 7'h70;
    localparam logic [6:0] RC_FIXED_DEF  = 7'h71;
    localparam logic [6:0] RC_DESC_CUR   = 7'h72;
    localparam logic [6:0] RC_DESC_DEF   = 7'h73;
    localparam logic [7:0] FIXED_MIN_LEN = 8'd14;
    localparam logic [7:0] DESC_MIN_LEN  = 8'd4;

    // Sense keys and additional sense codes of interest.
    localparam logic [3:0] KEY_NOT_READY  = 4'h2;
    localparam logic [3:0] KEY_UNIT_ATTN  = 4'h6;
    localparam logic [7:0] ASC_NO_MEDIUM  = 8'h3a;
    localparam logic [7:0] ASC_CHANGED    = 8'h28;

    // One input word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  response_length;
        logic [7:0]  head_byte0;
        logic [7:0]  head_byte1;
        logic [7:0]  head_byte2;
        logic [7:0]  head_byte4;
        logic [7:0]  sense_byte12;
        logic [63:0] gen_seen;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [63:0] generation;
        logic        eject_pending;
        logic [2:0]  media_event;
        logic        decode_ok;
        logic [3:0]  decoded_key;
        logic [7:0]  decoded_asc;
        logic        media_absent;
        logic        transitioned;
    } out_word_t;

    // Decoder results and the state updates they request.
    typedef struct packed {
        logic [2:0] ev;
        logic       ok;
        logic [3:0] key;
        logic [7:0] asc;
        logic       absent;
        logic       set_absent;
        logic       set_change;
        logic       set_eject;
        logic       clr_latches;
        logic       clr_eject;
    } decode_t;

endpackage

// ===== sv/omct_decode.sv =====
// Combinational decoder for one input word of the media change tracker.
// Parses event responses and sense data; depends on omct_pkg.
`timescale 1ns / 1ps

module omct_decode
    import omct_pkg::*;
(
    input  in_word_t item,
    output decode_t  dec
);

    logic [15:0] payload;
    logic [3:0]  ev_code;
    logic [6:0]  resp_code;
    logic        fixed_ok;
    logic        desc_ok;
    logic        ev_hdr_ok;

    // Event response header checks.
    assign payload   = {item.head_byte0, item.head_byte1};
    assign ev_code   = item.head_byte4[3:0];
    assign ev_hdr_ok = (item.head_byte2[2:0] == EV_CLASS_MEDIA) &&
                       (payload >= EV_MIN_PAYLOAD) &&
                       (item.response_length >= EV_FULL_LEN);

    // Sense format detection; bit 7 of the response code is ignored.
    assign resp_code = (item.response_length != 8'd0) ? item.head_byte0[6:0] : 7'd0;
    assign fixed_ok  = ((resp_code == RC_FIXED_CUR) || (resp_code == RC_FIXED_DEF)) &&
                       (item.response_length >= FIXED_MIN_LEN);
    assign desc_ok   = ((resp_code == RC_DESC_CUR) || (resp_code == RC_DESC_DEF)) &&
                       (item.response_length >= DESC_MIN_LEN);

    always_comb begin
        dec = '0;
        case (kind_t'(item.kind))
            KIND_EVENT: begin
                if (item.response_length >= EV_MIN_LEN) begin
                    if (item.head_byte2[7]) begin
                        dec.ok = 1'b1;
                    end else if (ev_hdr_ok) begin
                        dec.ok = 1'b1;
                        if ((ev_code >= 4'd1) && (ev_code <= 4'd4)) begin
                            dec.ev = ev_code[2:0];
                        end
                    end
                end
                dec.set_eject  = (dec.ev == EV_EJECT);
                dec.set_change = (dec.ev == EV_NEW) || (dec.ev == EV_REMOVAL) ||
                                 (dec.ev == EV_CHANGED);
            end
            KIND_SENSE: begin
                if (fixed_ok) begin
                    dec.ok  = 1'b1;
                    dec.key = item.head_byte2[3:0];
                    dec.asc = item.sense_byte12;
                end else if (desc_ok) begin
                    dec.ok  = 1'b1;
                    dec.key = item.head_byte1[3:0];
                    dec.asc = item.head_byte2;
                end
                dec.absent     = dec.ok && (dec.key == KEY_NOT_READY) &&
                                 (dec.asc == ASC_NO_MEDIUM);
                dec.set_absent = dec.absent;
                dec.set_change = dec.ok && (dec.key == KEY_UNIT_ATTN) &&
                                 (dec.asc == ASC_CHANGED);
            end
            KIND_READY: begin
                dec.clr_latches = 1'b1;
            end
            default: begin
                dec.clr_eject = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/omct_state.sv =====
// Tracker state: generation counter and the absence, change and eject latches.
// Applies the decoder's requests; depends on omct_pkg.
`timescale 1ns / 1ps

module omct_state
    import omct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             update,
    input  decode_t          dec,
    output logic [GEN_W-1:0] gen_next,
    output logic             eject_next
);

    logic [GEN_W-1:0] gen_reg;
    logic             absent_reg;
    logic             change_reg;
    logic             eject_reg;
    logic             absent_next;
    logic             change_next;
    logic             bump;

    // A notice bumps the generation only when neither latch is set yet.
    assign bump = (dec.set_absent || dec.set_change) && !absent_reg && !change_reg;

    always_comb begin
        gen_next = gen_reg;
        if (bump) begin
            if (gen_reg == {GEN_W{1'b1}}) begin
                gen_next = {{(GEN_W-1){1'b0}}, 1'b1};
            end else begin
                gen_next = gen_reg + {{(GEN_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // Latch updates.
    always_comb begin
        absent_next = (absent_reg || dec.set_absent) && !dec.clr_latches;
        change_next = (change_reg || dec.set_change) && !dec.clr_latches;
        eject_next  = eject_reg;
        if (dec.set_eject) begin
            eject_next = 1'b1;
        end else if (dec.set_absent || dec.set_change || dec.clr_eject) begin
            eject_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg    <= '0;
            absent_reg <= 1'b0;
            change_reg <= 1'b0;
            eject_reg  <= 1'b0;
        end else if (update) begin
            gen_reg    <= gen_next;
            absent_reg <= absent_next;
            change_reg <= change_next;
            eject_reg  <= eject_next;
        end
    end

endmodule

// ===== sv/optical_media_change_tracker_core.sv =====
// Top level of the optical media change tracker.
// Input register, decoder, state update and result register; uses omct_pkg,
// omct_decode and omct_state.
//
//   Port group | Dir | Handshake        | Word
//   s_*        | in  | s_valid/s_ready  | in_word_t
//   m_*        | out | m_valid/m_ready  | out_word_t
//
// Each accepted word passes through the input register, then through decode and
// state update into the result register. One word per cycle is sustained while
// m_ready does not stall the result; the state update is applied on each advance.
// Reset (aresetn low at a clock edge) clears both registers' valid bits and
// all tracker state. A stall on m_ready holds the result; the input register
// then fills and s_ready drops until the result is taken.
`timescale 1ns / 1ps

module optical_media_change_tracker_core
    import omct_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    in_word_t         in_data_reg;
    logic             in_valid_reg;
    out_word_t        out_data_reg;
    logic             out_valid_reg;
    out_word_t        out_data_next;
    logic             advance;
    decode_t          dec;
    logic [GEN_W-1:0] gen_next;
    logic             eject_next;
    logic [63:0]      gen_wide;

    // A word moves to the result register when that register is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    omct_decode u_decode (
        .item (in_data_reg),
        .dec  (dec)
    );

    omct_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .dec        (dec),
        .gen_next   (gen_next),
        .eject_next (eject_next)
    );

    // Assemble the result word from the decode and the updated state.
    assign gen_wide = 64'(gen_next);

    always_comb begin
        out_data_next.generation    = gen_wide;
        out_data_next.eject_pending = eject_next;
        out_data_next.media_event   = dec.ev;
        out_data_next.decode_ok     = dec.ok;
        out_data_next.decoded_key   = dec.key;
        out_data_next.decoded_asc   = dec.asc;
        out_data_next.media_absent  = dec.absent;
        out_data_next.transitioned  = (gen_wide != in_data_reg.gen_seen) || eject_next;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== sv/omct_checker.sv =====
// Port-level checks for the optical media change tracker.
// Depends on omct_pkg; bound to optical_media_change_tracker_core below.
`timescale 1ns / 1ps

module omct_checker
    import omct_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // A result under stall stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A pending eject always reports a transition.
    a_eject_trans: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.eject_pending |-> m_data.transitioned)
        else $error("eject pending without transition");

    // An eject request event leaves the eject latched.
    a_eject_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.media_event == EV_EJECT) |-> m_data.eject_pending)
        else $error("eject event without pending eject");

    // Media absence comes only from a decoded not-ready, no-medium sense.
    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.media_absent |->
            m_data.decode_ok && (m_data.decoded_key == KEY_NOT_READY) &&
            (m_data.decoded_asc == ASC_NO_MEDIUM) && !m_data.eject_pending &&
            (m_data.generation != 64'd0))
        else $error("media absent flag without matching sense");

endmodule

bind optical_media_change_tracker_core omct_checker u_omct_checker (.*);

// ===== test/omct_tracker_checker.sv =====
// Checker for the optical media change tracker: watches both channels,
// predicts each result word from the accepted input words, and compares them.
// Depends on omct_pkg for the word layouts, kinds and decode constants.
`timescale 1ns / 1ps

module omct_tracker_checker
    import omct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_word_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_word_t   m_data,
    output int          fail_count,
    output int          words_waiting,
    output logic [63:0] gen_hint
);

    localparam int PRINT_LIMIT = 60;

    // Predicted tracker state, cleared while reset is held.
    logic [GEN_W-1:0] media_gen;
    logic             absent_latch;
    logic             change_latch;
    logic             eject_latch;

    out_word_t due_results[$];
    int        mismatches = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
    endtask

    // The counter wraps within its width and never lands on zero.
    function automatic void step_generation();
        logic [GEN_W-1:0] next_gen;
        next_gen = media_gen + 1'b1;
        if (next_gen == '0)
            next_gen = {{(GEN_W-1){1'b0}}, 1'b1};
        media_gen = next_gen;
    endfunction

    // A notice only advances the generation if no latch is already set.
    function automatic void note_absent();
        if (!absent_latch && !change_latch)
            step_generation();
        absent_latch = 1'b1;
        eject_latch  = 1'b0;
    endfunction

    function automatic void note_changed();
        if (!absent_latch && !change_latch)
            step_generation();
        change_latch = 1'b1;
        eject_latch  = 1'b0;
    endfunction

    // Applies one input word to the predicted state and returns its result word.
    function automatic out_word_t advance_tracker(input in_word_t w);
        out_word_t   r;
        logic [15:0] ev_len;
        logic [3:0]  ev_code;
        logic [6:0]  rc;
        r = '0;
        case (kind_t'(w.kind))
            KIND_EVENT: begin
                ev_len  = {w.head_byte0, w.head_byte1};
                ev_code = w.head_byte4[3:0];
                if (w.response_length >= EV_MIN_LEN) begin
                    if (w.head_byte2[7]) begin
                        r.decode_ok = 1'b1;
                    end else if (w.head_byte2[2:0] == EV_CLASS_MEDIA &&
                                 ev_len >= EV_MIN_PAYLOAD &&
                                 w.response_length >= EV_FULL_LEN) begin
                        r.decode_ok = 1'b1;
                        if (ev_code >= EV_EJECT && ev_code <= EV_CHANGED)
                            r.media_event = ev_code[2:0];
                    end
                end
                if (r.media_event == EV_EJECT)
                    eject_latch = 1'b1;
                else if (r.media_event != EV_NONE)
                    note_changed();
            end
            KIND_SENSE: begin
                rc = (w.response_length != 0) ? w.head_byte0[6:0] : '0;
                if ((rc == RC_FIXED_CUR || rc == RC_FIXED_DEF) &&
                    w.response_length >= FIXED_MIN_LEN) begin
                    r.decode_ok   = 1'b1;
                    r.decoded_key = w.head_byte2[3:0];
                    r.decoded_asc = w.sense_byte12;
                end else if ((rc == RC_DESC_CUR || rc == RC_DESC_DEF) &&
                             w.response_length >= DESC_MIN_LEN) begin
                    r.decode_ok   = 1'b1;
                    r.decoded_key = w.head_byte1[3:0];
                    r.decoded_asc = w.head_byte2;
                end
                if (r.decode_ok) begin
                    if (r.decoded_key == KEY_NOT_READY && r.decoded_asc == ASC_NO_MEDIUM) begin
                        r.media_absent = 1'b1;
                        note_absent();
                    end else if (r.decoded_key == KEY_UNIT_ATTN &&
                                 r.decoded_asc == ASC_CHANGED) begin
                        note_changed();
                    end
                end
            end
            KIND_READY: begin
                absent_latch = 1'b0;
                change_latch = 1'b0;
            end
            default: begin
                eject_latch = 1'b0;
            end
        endcase
        r.generation    = media_gen;
        r.eject_pending = eject_latch;
        r.transitioned  = (64'(media_gen) != w.gen_seen) || eject_latch;
        return r;
    endfunction

    // Both channels are sampled at the clock edge; the results side is checked
    // before the input side so a word never meets its own prediction early.
    always @(posedge aclk) begin : watch
        out_word_t want;
        if (!aresetn) begin
            media_gen    = '0;
            absent_latch = 1'b0;
            change_latch = 1'b0;
            eject_latch  = 1'b0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result word", m_data.generation, '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.generation !== want.generation)
                        report_mismatch("generation", m_data.generation, want.generation);
                    if (m_data.eject_pending !== want.eject_pending)
                        report_mismatch("eject_pending", 64'(m_data.eject_pending),
                                        64'(want.eject_pending));
                    if (m_data.media_event !== want.media_event)
                        report_mismatch("media_event", 64'(m_data.media_event),
                                        64'(want.media_event));
                    if (m_data.decode_ok !== want.decode_ok)
                        report_mismatch("decode_ok", 64'(m_data.decode_ok),
                                        64'(want.decode_ok));
                    if (m_data.decoded_key !== want.decoded_key)
                        report_mismatch("decoded_key", 64'(m_data.decoded_key),
                                        64'(want.decoded_key));
                    if (m_data.decoded_asc !== want.decoded_asc)
                        report_mismatch("decoded_asc", 64'(m_data.decoded_asc),
                                        64'(want.decoded_asc));
                    if (m_data.media_absent !== want.media_absent)
                        report_mismatch("media_absent", 64'(m_data.media_absent),
                                        64'(want.media_absent));
                    if (m_data.transitioned !== want.transitioned)
                        report_mismatch("transitioned", 64'(m_data.transitioned),
                                        64'(want.transitioned));
                end
            end
            if (s_valid && s_ready)
                due_results.push_back(advance_tracker(s_data));
        end
        fail_count    <= mismatches;
        words_waiting <= due_results.size();
        gen_hint      <= 64'(media_gen);
    end

endmodule

// ===== test/tb_optical_media_change_tracker_core.sv =====
// Testbench top for the optical media change tracker core.
// Drives directed and random reply words with random idling on both sides;
// uses omct_pkg, the core and omct_tracker_checker.
`timescale 1ns / 1ps

module tb_optical_media_change_tracker_core
    import omct_pkg::*;
();

    localparam int ITEM_COUNT  = 1150;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_word_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_word_t m_data;

    int          fail_count;
    int          words_waiting;
    logic [63:0] gen_hint;
    logic        calm        = 1'b0;
    int          cycle_count = 0;
    int          ready_hold  = 0;

    optical_media_change_tracker_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    omct_tracker_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .words_waiting (words_waiting),
        .gen_hint      (gen_hint)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result-side back pressure: mostly ready, short stalls, a few long ones.
    always @(posedge aclk) begin : result_stall
        int pick;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            m_ready <= (pick < 70);
            if (pick < 70)
                ready_hold <= $urandom_range(0, 6);
            else if (pick < 95)
                ready_hold <= $urandom_range(0, 3);
            else
                ready_hold <= $urandom_range(10, 50);
        end
    end

    // Expected generation: mostly near the predicted count so both answers occur.
    function automatic logic [63:0] pick_expected();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)
            return gen_hint;
        else if (p < 6)
            return gen_hint + 64'($urandom_range(0, 2)) - 64'd1;
        else
            return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic in_word_t reply_word(input kind_t k, input logic [7:0] len,
                                            input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b4,
                                            input logic [7:0] s12);
        in_word_t w;
        w.kind            = k;
        w.response_length = len;
        w.head_byte0      = b0;
        w.head_byte1      = b1;
        w.head_byte2      = b2;
        w.head_byte4      = b4;
        w.sense_byte12    = s12;
        w.gen_seen        = pick_expected();
        return w;
    endfunction

    // Holds valid until the word is taken, then idles for a random gap.
    task automatic send_word(input in_word_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        in_word_t   w;
        int         pick;
        logic [3:0] key;
        logic [7:0] asc;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: field extremes and each decode corner.
        send_word(reply_word(KIND_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        w = reply_word(KIND_SESSION, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        w.gen_seen = '1;
        send_word(w);
        // Short event response, then the no-event flag.
        send_word(reply_word(KIND_EVENT, 8'd3, 8'h00, 8'h06, 8'h04, 8'h02, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'd4, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00));
        // Bad headers: wrong class, short declared length, too few bytes.
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h03, 8'h02, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h05, 8'h04, 8'h02, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'd7, 8'h00, 8'h06, 8'h04, 8'h02, 8'h00));
        // Eject request twice, then the session mark clears it.
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h04, 8'h01, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h01, 8'h00, 8'h7c, 8'hf1, 8'h00));
        send_word(reply_word(KIND_SESSION, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // New media bumps; removal behind a set latch does not; ready clears.
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h04, 8'h02, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'hff, 8'hff, 8'hff, 8'h04, 8'h03, 8'h00));
        send_word(reply_word(KIND_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h04, 8'h04, 8'h00));
        send_word(reply_word(KIND_READY, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        // Unknown event codes.
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h04, 8'h05, 8'h00));
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h04, 8'hff, 8'h00));
        // Eject pending, then a fixed sense with bit 7 set reporting no medium.
        send_word(reply_word(KIND_EVENT, 8'd8, 8'h00, 8'h06, 8'h04, 8'h01, 8'h00));
        send_word(reply_word(KIND_SENSE, 8'd14, 8'hf0, 8'h00, 8'h02, 8'h00, 8'h3a));
        // Fixed sense one byte short; descriptor change behind a set latch.
        send_word(reply_word(KIND_SENSE, 8'd13, 8'h71, 8'h00, 8'h06, 8'h00, 8'h28));
        send_word(reply_word(KIND_SENSE, 8'd4, 8'h72, 8'h06, 8'h28, 8'h00, 8'h00));
        send_word(reply_word(KIND_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(reply_word(KIND_SENSE, 8'hff, 8'hf3, 8'hf6, 8'h28, 8'h00, 8'h00));
        // Zero length, unknown response code, descriptor one byte short.
        send_word(reply_word(KIND_SENSE, 8'd0, 8'h70, 8'h00, 8'h02, 8'h00, 8'h3a));
        send_word(reply_word(KIND_SENSE, 8'd20, 8'h74, 8'h02, 8'h3a, 8'h00, 8'h3a));
        send_word(reply_word(KIND_SENSE, 8'd3, 8'h73, 8'h02, 8'h3a, 8'h00, 8'h00));

        // Random words: mostly well-formed replies with random content.
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % 64 == 0)
                calm <= ($urandom_range(0, 3) == 0);
            w = reply_word(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                w.kind = KIND_EVENT;
                w.response_length = ($urandom_range(0, 3) == 0) ? EV_FULL_LEN
                                                                : 8'($urandom_range(8, 255));
                if ($urandom_range(0, 1))
                    w.head_byte0 = 8'h00;
                if (w.head_byte0 == 8'h00 && w.head_byte1 < 8'd6)
                    w.head_byte1 = 8'($urandom_range(6, 255));
                w.head_byte2 = {1'b0, w.head_byte2[6:3], EV_CLASS_MEDIA};
                w.head_byte4[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                                : 4'($urandom_range(1, 4));
            end else if (pick < 60) begin
                w.kind = KIND_SENSE;
                case ($urandom_range(0, 4))
                    0, 1: begin
                        key = KEY_NOT_READY;
                        asc = ASC_NO_MEDIUM;
                    end
                    2, 3: begin
                        key = KEY_UNIT_ATTN;
                        asc = ASC_CHANGED;
                    end
                    default: begin
                        key = 4'($urandom);
                        asc = 8'($urandom);
                    end
                endcase
                if ($urandom_range(0, 1)) begin
                    w.head_byte0        = {w.head_byte0[7], RC_FIXED_CUR[6:1], w.head_byte0[0]};
                    w.response_length   = 8'($urandom_range(14, 255));
                    w.head_byte2[3:0]   = key;
                    w.sense_byte12      = asc;
                end else begin
                    w.head_byte0        = {w.head_byte0[7], RC_DESC_CUR[6:1], w.head_byte0[0]};
                    w.response_length   = 8'($urandom_range(4, 255));
                    w.head_byte1[3:0]   = key;
                    w.head_byte2        = asc;
                end
            end else if (pick < 72) begin
                w.kind = KIND_READY;
            end else if (pick < 80) begin
                w.kind = KIND_SESSION;
            end else if (pick < 90) begin
                // Truncated replies with otherwise plausible headers.
                if ($urandom_range(0, 1)) begin
                    w.kind = KIND_EVENT;
                    w.response_length = 8'($urandom_range(0, 7));
                    w.head_byte2[2:0] = EV_CLASS_MEDIA;
                end else begin
                    w.kind = KIND_SENSE;
                    w.response_length = 8'($urandom_range(0, 13));
                    w.head_byte0[6:1] = RC_FIXED_CUR[6:1];
                end
            end
            send_word(w);
        end

        // Drain: let the last acceptance register, then wait for every result.
        s_valid <= 1'b0;
        calm    <= 1'b0;
        do
            @(posedge aclk);
        while (words_waiting != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
